>>> rtl/shell_word_tokenizer_unit_assert.svh
// Assertion macros shared by the shell word tokenizer RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef SHELL_WORD_TOKENIZER_UNIT_ASSERT_SVH
`define SHELL_WORD_TOKENIZER_UNIT_ASSERT_SVH

// expr must hold at every clock edge out of reset
`define SWT_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// cons must hold in the cycle after ante
`define SWT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/swt_pkg.sv
// Types and constants for the shell word tokenizer.
// No dependencies; used by swt_step and shell_word_tokenizer_unit.
`default_nettype none

package swt_pkg;

    localparam int MAX_RESULTS = 3;

    // character codes
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_BTICK   = 8'h60;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_END   = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_TRAIL_BSLASH = 2'd1,
        ERR_UNTERM_QUOTE = 2'd2,
        ERR_EMPTY_ARGS   = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        MODE_PLAIN  = 2'd0,
        MODE_DOUBLE = 2'd1,
        MODE_SINGLE = 2'd2
    } mode_t;

    typedef struct packed {
        mode_t mode;
        logic  escape_pending;
        logic  token_open;
        logic  any_token_seen;
    } tok_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  out_byte;
        err_t        error_code;
        logic        last;
    } result_t;

    // all results caused by one input request
    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        logic [1:0]                count;
    } bundle_t;

endpackage

`default_nettype wire

>>> rtl/swt_step.sv
// Per-byte tokenizer decision: next state and the results of one request.
// Depends on swt_pkg.
`default_nettype none

module swt_step (
    input  swt_pkg::tok_state_t cur_state,
    input  logic [7:0]          data_byte,
    input  logic                byte_present,
    input  logic                end_of_payload,
    output swt_pkg::tok_state_t next_state,
    output swt_pkg::bundle_t    bundle
);
    import swt_pkg::*;

    function automatic result_t make_res(kind_t k, logic [7:0] b, err_t e);
        result_t r;
        r.kind       = k;
        r.out_byte   = b;
        r.error_code = e;
        r.last       = 1'b0;
        return r;
    endfunction

    always_comb
    begin
        tok_state_t                st;
        result_t [MAX_RESULTS-1:0] res;
        logic [1:0]                n;
        logic                      blank;
        logic                      dq_esc;

        st     = cur_state;
        res    = '0;
        n      = 2'd0;
        blank  = (data_byte == CH_SPACE) || (data_byte == CH_TAB) || (data_byte == CH_NL);
        dq_esc = (data_byte == CH_DQUOTE) || (data_byte == CH_BSLASH) ||
                 (data_byte == CH_DOLLAR) || (data_byte == CH_BTICK) || (data_byte == CH_NL);

        // byte handling by quote mode
        if (byte_present)
        begin
            unique case (st.mode)
                MODE_DOUBLE:
                begin
                    if (st.escape_pending)
                    begin
                        st.escape_pending = 1'b0;
                        // unescapable byte keeps its backslash
                        if (!dq_esc)
                        begin
                            res[n] = make_res(KIND_BYTE, CH_BSLASH, ERR_NONE);
                            n      = n + 2'd1;
                        end
                        res[n] = make_res(KIND_BYTE, data_byte, ERR_NONE);
                        n      = n + 2'd1;
                    end
                    else if (data_byte == CH_DQUOTE)
                    begin
                        st.mode = MODE_PLAIN;
                    end
                    else if (data_byte == CH_BSLASH)
                    begin
                        st.escape_pending = 1'b1;
                    end
                    else
                    begin
                        res[n] = make_res(KIND_BYTE, data_byte, ERR_NONE);
                        n      = n + 2'd1;
                    end
                end
                MODE_SINGLE:
                begin
                    if (data_byte == CH_SQUOTE)
                    begin
                        st.mode = MODE_PLAIN;
                    end
                    else
                    begin
                        res[n] = make_res(KIND_BYTE, data_byte, ERR_NONE);
                        n      = n + 2'd1;
                    end
                end
                default:
                begin
                    // unquoted; the unused mode code falls here too
                    st.mode = MODE_PLAIN;
                    if (st.escape_pending)
                    begin
                        st.escape_pending = 1'b0;
                        st.token_open     = 1'b1;
                        res[n] = make_res(KIND_BYTE, data_byte, ERR_NONE);
                        n      = n + 2'd1;
                    end
                    else if (blank)
                    begin
                        if (st.token_open)
                        begin
                            res[n] = make_res(KIND_END, 8'h00, ERR_NONE);
                            n      = n + 2'd1;
                            st.token_open     = 1'b0;
                            st.any_token_seen = 1'b1;
                        end
                    end
                    else if (data_byte == CH_DQUOTE)
                    begin
                        st.mode       = MODE_DOUBLE;
                        st.token_open = 1'b1;
                    end
                    else if (data_byte == CH_SQUOTE)
                    begin
                        st.mode       = MODE_SINGLE;
                        st.token_open = 1'b1;
                    end
                    else if (data_byte == CH_BSLASH)
                    begin
                        st.escape_pending = 1'b1;
                    end
                    else
                    begin
                        res[n] = make_res(KIND_BYTE, data_byte, ERR_NONE);
                        n      = n + 2'd1;
                        st.token_open = 1'b1;
                    end
                end
            endcase
        end

        // end of payload: flush, report, clear
        if (end_of_payload)
        begin
            if ((st.mode == MODE_DOUBLE) || (st.mode == MODE_SINGLE))
            begin
                res[n] = make_res(KIND_ERROR, 8'h00, ERR_UNTERM_QUOTE);
                n      = n + 2'd1;
            end
            else if (st.escape_pending)
            begin
                res[n] = make_res(KIND_ERROR, 8'h00, ERR_TRAIL_BSLASH);
                n      = n + 2'd1;
            end
            else
            begin
                if (st.token_open)
                begin
                    res[n] = make_res(KIND_END, 8'h00, ERR_NONE);
                    n      = n + 2'd1;
                    st.any_token_seen = 1'b1;
                end
                if (st.any_token_seen)
                    res[n] = make_res(KIND_DONE, 8'h00, ERR_NONE);
                else
                    res[n] = make_res(KIND_ERROR, 8'h00, ERR_EMPTY_ARGS);
                n = n + 2'd1;
            end
            st.mode           = MODE_PLAIN;
            st.escape_pending = 1'b0;
            st.token_open     = 1'b0;
            st.any_token_seen = 1'b0;
        end

        // mark the final result of this request
        if (n != 2'd0)
            res[n - 2'd1].last = 1'b1;

        next_state   = st;
        bundle.res   = res;
        bundle.count = n;
    end

endmodule

`default_nettype wire

>>> rtl/shell_word_tokenizer_unit.sv
// Shell word tokenizer: input register, per-byte decision (swt_step),
// a two-entry result queue and a one-result-per-cycle output serializer, when not stalled.
// A request is held in the input register, then its results are written into the
// result queue once the queue has room; the first result is offered once it is queued.
// Throughput: one request per cycle while each yields at most one result and the output
// is not stalled; results leave at one per cycle, each result of a request in turn.
// Reset (rst_n low, async): tokenizer state unquoted and cleared, queue empty.
`default_nettype none
`include "shell_word_tokenizer_unit_assert.svh"

module shell_word_tokenizer_unit (
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_present
    input  logic        s_axis_tlast,   // end_of_payload
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [1:0] kind, [9:2] out_byte, [11:10] error_code
    output logic        m_axis_tlast    // last
);
    import swt_pkg::*;

    localparam int QDepth = 2;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_present_reg;
    logic       in_eop_reg;

    tok_state_t state_reg;
    tok_state_t state_next;
    bundle_t    step_bundle;

    // result queue
    bundle_t    q_reg [QDepth];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] q_count_reg;
    logic [1:0] sub_reg;

    logic    room;
    logic    advance;
    logic    push;
    logic    pop;
    logic    out_fire;
    bundle_t head;
    result_t head_res;

    swt_step u_step (
        .cur_state      (state_reg),
        .data_byte      (in_byte_reg),
        .byte_present   (in_present_reg),
        .end_of_payload (in_eop_reg),
        .next_state     (state_next),
        .bundle         (step_bundle)
    );

    assign room          = (q_count_reg != 2'(QDepth));
    assign advance       = in_valid_reg && room;
    assign push          = advance && (step_bundle.count != 2'd0);
    assign s_axis_tready = !in_valid_reg || room;

    // output side
    assign head          = q_reg[rd_ptr_reg];
    assign head_res      = head.res[sub_reg];
    assign m_axis_tvalid = (q_count_reg != 2'd0);
    assign m_axis_tdata  = {4'b0000, head_res.error_code, head_res.out_byte, head_res.kind};
    assign m_axis_tlast  = head_res.last;
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign pop           = out_fire && (sub_reg == (head.count - 2'd1));

    // input register and tokenizer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '{mode: MODE_PLAIN, escape_pending: 1'b0,
                              token_open: 1'b0, any_token_seen: 1'b0};
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg    <= s_axis_tdata;
            in_present_reg <= s_axis_tuser;
            in_eop_reg     <= s_axis_tlast;
        end
        if (push)
            q_reg[wr_ptr_reg] <= step_bundle;
    end

    // queue pointers and serializer position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
            q_count_reg <= 2'd0;
            sub_reg     <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            unique case ({push, pop})
                2'b10:   q_count_reg <= q_count_reg + 2'd1;
                2'b01:   q_count_reg <= q_count_reg - 2'd1;
                default: q_count_reg <= q_count_reg;
            endcase
            if (pop)
                sub_reg <= 2'd0;
            else if (out_fire)
                sub_reg <= sub_reg + 2'd1;
        end
    end

    // checks
    `SWT_ASSERT_ALWAYS(a_qcount_bound, q_count_reg <= 2'(QDepth), "result queue overfilled")
    `SWT_ASSERT_ALWAYS(a_sub_in_bundle, !m_axis_tvalid || (sub_reg < head.count),
        "serializer index past bundle")
    `SWT_ASSERT_ALWAYS(a_final_is_last,
        !m_axis_tvalid || !((head_res.kind == KIND_DONE) || (head_res.kind == KIND_ERROR))
        || m_axis_tlast, "payload status not marked last")
    `SWT_ASSERT_NEXT(a_eop_clears, advance && in_eop_reg,
        (state_reg.mode == MODE_PLAIN) && !state_reg.escape_pending &&
        !state_reg.token_open && !state_reg.any_token_seen, "state not cleared at payload end")

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for shell_word_tokenizer_unit: streams byte requests in,
// predicts the word-splitting results and compares every result field by field.
// Depends on swt_pkg and the shell_word_tokenizer_unit RTL.
`default_nettype none

module tb_top;
    import swt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_LEN    = 200;
    localparam int DRAIN_WAIT  = 20;

    // one input request: byte, byte-valid flag, end of payload
    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       eop;
    } byte_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;     // [7:0] data_byte
    logic        s_axis_tuser = 1'b0;     // [0] byte_present
    logic        s_axis_tlast = 1'b0;     // end_of_payload
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;            // [1:0] kind, [9:2] out_byte, [11:10] error_code
    logic        m_axis_tlast;            // last

    byte_req_t   pending_reqs[$];
    result_t     due_results[$];
    result_t     step_res[$];
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    bit          hold_go = 1'b0;
    int          hold_cycles = 0;
    bit          req_taken = 1'b0;
    int          fail_count = 0;
    int          cycle_count = 0;

    // splitter state mirrored by the predictor
    mode_t       tok_mode = MODE_PLAIN;
    bit          tok_escape = 1'b0;
    bit          tok_open = 1'b0;
    bit          tok_seen = 1'b0;

    shell_word_tokenizer_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    function automatic result_t make_result(kind_t k, logic [7:0] b, err_t e);
        result_t r;
        r.kind       = k;
        r.out_byte   = b;
        r.error_code = e;
        r.last       = 1'b0;
        return r;
    endfunction

    // append one result of the current step
    function automatic void emit_result(kind_t k, logic [7:0] b, err_t e);
        step_res.insert(step_res.size(), make_result(k, b, e));
    endfunction

    // word splitting for one accepted request; queues its results
    task automatic tokenize_item(input byte_req_t req);
        result_t    tail;
        logic [7:0] b;
        step_res.delete();
        b = req.data;
        if (req.present)
        begin
            if (tok_mode == MODE_DOUBLE)
            begin
                if (tok_escape)
                begin
                    tok_escape = 1'b0;
                    // backslash kept before a byte it cannot escape
                    if (!(b inside {CH_DQUOTE, CH_BSLASH, CH_DOLLAR, CH_BTICK, CH_NL}))
                        emit_result(KIND_BYTE, CH_BSLASH, ERR_NONE);
                    emit_result(KIND_BYTE, b, ERR_NONE);
                end
                else if (b == CH_DQUOTE)
                    tok_mode = MODE_PLAIN;
                else if (b == CH_BSLASH)
                    tok_escape = 1'b1;
                else
                    emit_result(KIND_BYTE, b, ERR_NONE);
            end
            else if (tok_mode == MODE_SINGLE)
            begin
                if (b == CH_SQUOTE)
                    tok_mode = MODE_PLAIN;
                else
                    emit_result(KIND_BYTE, b, ERR_NONE);
            end
            else
            begin
                tok_mode = MODE_PLAIN;
                if (tok_escape)
                begin
                    tok_escape = 1'b0;
                    emit_result(KIND_BYTE, b, ERR_NONE);
                    tok_open = 1'b1;
                end
                else if (b inside {CH_SPACE, CH_TAB, CH_NL})
                begin
                    if (tok_open)
                    begin
                        emit_result(KIND_END, 8'd0, ERR_NONE);
                        tok_open = 1'b0;
                        tok_seen = 1'b1;
                    end
                end
                else if (b == CH_DQUOTE)
                begin
                    tok_mode = MODE_DOUBLE;
                    tok_open = 1'b1;
                end
                else if (b == CH_SQUOTE)
                begin
                    tok_mode = MODE_SINGLE;
                    tok_open = 1'b1;
                end
                else if (b == CH_BSLASH)
                    tok_escape = 1'b1;
                else
                begin
                    emit_result(KIND_BYTE, b, ERR_NONE);
                    tok_open = 1'b1;
                end
            end
        end
        // payload close: flush the word, then report done or an error
        if (req.eop)
        begin
            if (tok_mode == MODE_DOUBLE || tok_mode == MODE_SINGLE)
                emit_result(KIND_ERROR, 8'd0, ERR_UNTERM_QUOTE);
            else if (tok_escape)
                emit_result(KIND_ERROR, 8'd0, ERR_TRAIL_BSLASH);
            else
            begin
                if (tok_open)
                begin
                    emit_result(KIND_END, 8'd0, ERR_NONE);
                    tok_seen = 1'b1;
                end
                if (tok_seen)
                    emit_result(KIND_DONE, 8'd0, ERR_NONE);
                else
                    emit_result(KIND_ERROR, 8'd0, ERR_EMPTY_ARGS);
            end
            tok_mode   = MODE_PLAIN;
            tok_escape = 1'b0;
            tok_open   = 1'b0;
            tok_seen   = 1'b0;
        end
        if (step_res.size() > 0)
        begin
            tail = step_res[step_res.size() - 1];
            tail.last = 1'b1;
            step_res[step_res.size() - 1] = tail;
        end
        foreach (step_res[i])
            due_results.insert(due_results.size(), step_res[i]);
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // accept-side prediction and result checking
    always @(posedge clk)
    begin
        result_t exp_res;
        req_taken = rst_n && s_axis_tvalid && s_axis_tready;
        if (req_taken)
            tokenize_item('{s_axis_tdata, s_axis_tuser, s_axis_tlast});
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (due_results.size() == 0)
            begin
                $error("unexpected result: tdata=%h last=%b", m_axis_tdata, m_axis_tlast);
                fail_count++;
            end
            else
            begin
                exp_res = due_results.pop_front();
                check_field("kind", exp_res.kind, m_axis_tdata[1:0]);
                check_field("out_byte", exp_res.out_byte, m_axis_tdata[9:2]);
                check_field("error_code", exp_res.error_code, m_axis_tdata[11:10]);
                check_field("tdata_pad", 0, m_axis_tdata[15:12]);
                check_field("last", exp_res.last, m_axis_tlast);
            end
        end
    end

    // request driver
    always @(negedge clk)
    begin
        byte_req_t req;
        if (rst_n && (!s_axis_tvalid || req_taken))
        begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle_pct)
            begin
                req = pending_reqs.pop_front();
                s_axis_tdata  <= req.data;
                s_axis_tuser  <= req.present;
                s_axis_tlast  <= req.eop;
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // long receiver hold-off, counted on its own
    always @(posedge clk)
    begin
        if (hold_go && hold_cycles < HOLD_LEN)
            hold_cycles <= hold_cycles + 1;
    end

    // result receiver
    always @(negedge clk)
    begin
        if (!rst_n || (hold_go && hold_cycles < HOLD_LEN))
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void push_req(input logic [7:0] b, input logic present,
                                     input logic eop);
        byte_req_t r;
        r = '{b, present, eop};
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    function automatic logic [7:0] pick_special();
        logic [7:0] specials[8];
        specials = '{CH_SPACE, CH_TAB, CH_NL, CH_DQUOTE, CH_SQUOTE, CH_BSLASH,
                     CH_DOLLAR, CH_BTICK};
        return specials[$urandom_range(7)];
    endfunction

    function automatic logic [7:0] pick_plain();
        logic [7:0] b;
        if ($urandom_range(3) == 0)
            b = 8'h80 + 8'($urandom_range(127));
        else
            b = 8'h61 + 8'($urandom_range(25));
        return b;
    endfunction

    function automatic logic [7:0] pick_any();
        if ($urandom_range(1) == 0)
            return pick_special();
        return 8'($urandom_range(255));
    endfunction

    // one payload, well-formed words or noise; returns the requests queued
    function automatic int push_payload(input bit well_formed);
        logic [7:0] body[$];
        int         n_words;
        int         n_seg;
        int         n_chars;
        int         queued;
        logic [7:0] b;
        queued = 0;
        if (well_formed)
        begin
            n_words = $urandom_range(3);
            for (int w = 0; w < n_words; w++)
            begin
                repeat ($urandom_range(2))
                    body.insert(body.size(),
                                pick_special() inside {CH_SPACE, CH_TAB, CH_NL} ?
                                CH_SPACE : CH_TAB);
                n_seg = $urandom_range(1, 3);
                for (int s = 0; s < n_seg; s++)
                begin
                    n_chars = $urandom_range(3);
                    case ($urandom_range(3))
                        0:
                        begin
                            repeat (n_chars + 1)
                                body.insert(body.size(), pick_plain());
                        end
                        1:
                        begin
                            body.insert(body.size(), CH_BSLASH);
                            body.insert(body.size(), pick_any());
                        end
                        2:
                        begin
                            body.insert(body.size(), CH_DQUOTE);
                            repeat (n_chars)
                            begin
                                if ($urandom_range(2) == 0)
                                begin
                                    body.insert(body.size(), CH_BSLASH);
                                    body.insert(body.size(), pick_any());
                                end
                                else
                                begin
                                    b = pick_any();
                                    body.insert(body.size(),
                                                b == CH_DQUOTE || b == CH_BSLASH ?
                                                CH_DOLLAR : b);
                                end
                            end
                            body.insert(body.size(), CH_DQUOTE);
                        end
                        default:
                        begin
                            body.insert(body.size(), CH_SQUOTE);
                            repeat (n_chars)
                            begin
                                b = pick_any();
                                body.insert(body.size(), b == CH_SQUOTE ? CH_BSLASH : b);
                            end
                            body.insert(body.size(), CH_SQUOTE);
                        end
                    endcase
                end
                if ($urandom_range(1) == 0)
                    body.insert(body.size(), CH_NL);
            end
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                body.insert(body.size(), pick_any());
        end
        // close either on the last byte or with an end-only request
        foreach (body[i])
        begin
            if ($urandom_range(9) == 0)
            begin
                push_req(8'($urandom_range(255)), 1'b0, 1'b0);
                queued++;
            end
            push_req(body[i], 1'b1, (i == body.size() - 1) && $urandom_range(1) == 0);
            queued++;
        end
        if (body.size() == 0 || !pending_reqs[pending_reqs.size() - 1].eop)
        begin
            push_req(8'($urandom_range(255)), 1'b0, 1'b1);
            queued++;
        end
        return queued;
    endfunction

    task automatic push_random(input int n_reqs);
        int queued;
        queued = 0;
        while (queued < n_reqs)
            queued += push_payload($urandom_range(99) < 80);
    endtask

    task automatic run_phase(input int src_pct, input int sink_pct, input int n_reqs);
        @(posedge clk);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        push_random(n_reqs);
        wait (pending_reqs.size() == 0 && !s_axis_tvalid && due_results.size() == 0);
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed: empty request and empty argument list
        push_req(8'h00, 1'b0, 1'b0);
        push_req(8'hFF, 1'b0, 1'b1);
        // field extremes split by a tab
        push_req(8'h00, 1'b1, 1'b0);
        push_req(CH_TAB, 1'b1, 1'b0);
        push_req(8'hFF, 1'b1, 1'b1);
        // double quotes: escaped dollar, escape fallback, newline closes word
        push_req(CH_DQUOTE, 1'b1, 1'b0);
        push_req(CH_BSLASH, 1'b1, 1'b0);
        push_req(CH_DOLLAR, 1'b1, 1'b0);
        push_req(CH_BSLASH, 1'b1, 1'b0);
        push_req(8'h71, 1'b1, 1'b0);
        push_req(CH_DQUOTE, 1'b1, 1'b0);
        push_req(CH_NL, 1'b1, 1'b1);
        // empty quoted word
        push_req(CH_SQUOTE, 1'b1, 1'b0);
        push_req(CH_SQUOTE, 1'b1, 1'b1);
        // trailing backslash
        push_req(8'h61, 1'b1, 1'b0);
        push_req(CH_BSLASH, 1'b1, 1'b1);
        // unterminated single quote, backslash is raw inside
        push_req(CH_SQUOTE, 1'b1, 1'b0);
        push_req(CH_BSLASH, 1'b1, 1'b1);
        // unterminated double quote with a pending backslash
        push_req(CH_DQUOTE, 1'b1, 1'b0);
        push_req(CH_BSLASH, 1'b1, 1'b0);
        push_req(8'h00, 1'b0, 1'b1);
        // escaped blank then close: three results from one request
        push_req(CH_BSLASH, 1'b1, 1'b0);
        push_req(CH_SPACE, 1'b1, 1'b1);
        // blanks only
        push_req(CH_SPACE, 1'b1, 1'b0);
        push_req(CH_NL, 1'b1, 1'b1);
        // escaped backtick and quote inside double quotes, left open
        push_req(CH_DQUOTE, 1'b1, 1'b0);
        push_req(CH_BSLASH, 1'b1, 1'b0);
        push_req(CH_BTICK, 1'b1, 1'b0);
        push_req(CH_BSLASH, 1'b1, 1'b0);
        push_req(CH_DQUOTE, 1'b1, 1'b1);
        wait (pending_reqs.size() == 0 && !s_axis_tvalid && due_results.size() == 0);

        run_phase(0, 0, 40);
        run_phase(65, 0, 40);

        // receiver holds off while the sender keeps offering requests
        @(posedge clk);
        hold_go = 1'b1;
        run_phase(0, 0, 30);

        run_phase(0, 65, 40);
        run_phase(9, 9, 40);

        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0 && due_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
